[rtl/core/brwlt_pkg.sv]
// Types and codes shared by the block reader/writer lock table.
package brwlt_pkg;

	// Request codes carried in the low bits of s_tuser
	typedef logic [2:0] req_code_t;
	localparam req_code_t REQ_ACQ_READ  = 3'd0;
	localparam req_code_t REQ_ACQ_WRITE = 3'd1;
	localparam req_code_t REQ_REL_READ  = 3'd2;
	localparam req_code_t REQ_REL_WRITE = 3'd3;
	localparam req_code_t REQ_DISCARD   = 3'd4;

	// Status codes carried in m_tuser
	typedef logic [2:0] status_t;
	localparam status_t ST_GRANTED  = 3'd0;
	localparam status_t ST_WAIT     = 3'd1;
	localparam status_t ST_REFUSED  = 3'd2;
	localparam status_t ST_RELEASED = 3'd3;
	localparam status_t ST_DISCARD  = 3'd4;
	localparam status_t ST_ERROR    = 3'd5;

	// Counter widths and their saturation points
	localparam int GLOBAL_W    = 16;
	localparam int BLK_WR_W    = 7;
	localparam int BLK_LOCK_W  = 13;
	localparam int READERS_W   = 8;
	localparam int CAP_W       = 7;
	localparam int BLOCK_W     = 32;

	localparam logic [GLOBAL_W-1:0]   GLOBAL_MAX   = '1;
	localparam logic [BLK_WR_W-1:0]   BLK_WR_MAX   = '1;
	localparam logic [BLK_LOCK_W-1:0] BLK_LOCK_MAX = '1;
	localparam logic [CAP_W-1:0]      CAP_RESET    = 7'd16;

endpackage

[rtl/core/block_reader_writer_lock_table_top.sv]
// Block reader/writer lock table: input register, combinational resolve, result register.
//
// Each request names a lock operation on one block or on all blocks and gets exactly
// one result: granted, wait (retry later, nothing changed), refused while discarding,
// released, discard set, or error. One request is taken every cycle when results
// are drained; a request is held in the input register, where the parallel tag
// match over the TABLE_DEPTH entries, the lowest-free-entry search and the maintained
// lock totals resolve it, and its result is written to the output register once that
// register is free or being drained, ready for the result transfer. The table and
// totals are updated at the same edge, so the following request already sees them.
// write_cap may only be written while no request is in flight.
module block_reader_writer_lock_table_top #(
	parameter int TABLE_DEPTH = 16,
	parameter int MAX_READERS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,   // write_cap
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // [31:0] block_number
	input  logic [4:0]  s_tuser,       // [2:0] req_type, [3] is_global, [4] even_if_discarding
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,       // [7:0] block_readers, [8] block_writer, [15:9] zero
	output logic [2:0]  m_tuser        // [2:0] status
);
	import brwlt_pkg::*;

	localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int READER_LIMIT = (MAX_READERS < 255) ? MAX_READERS : 255;

	// Control state
	logic                  valid_s1;
	logic                  out_valid_q;
	logic [CAP_W-1:0]      write_cap_q;
	logic                  discard_q;
	logic [GLOBAL_W-1:0]   glob_rd_q;
	logic [GLOBAL_W-1:0]   glob_wr_q;
	logic [BLK_WR_W-1:0]   blk_wr_total_q;
	logic [BLK_LOCK_W-1:0] blk_lock_total_q;
	logic [TABLE_DEPTH-1:0] ent_valid_q;
	logic [READERS_W-1:0]  ent_readers_q [TABLE_DEPTH];
	logic                  ent_writer_q [TABLE_DEPTH];
	logic [BLOCK_W-1:0]    ent_block_q [TABLE_DEPTH];

	// Input register payload
	req_code_t             req_type_s1;
	logic                  is_global_s1;
	logic [BLOCK_W-1:0]    block_s1;
	logic                  even_s1;

	// Result register payload
	status_t               status_q;
	logic [READERS_W-1:0]  out_readers_q;
	logic                  out_writer_q;

	logic in_xfer;
	logic advance;

	// Resolve one request only when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	// Tag match and lowest free entry
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (ent_valid_q[i] && ent_block_q[i] == block_s1) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!ent_valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	logic [READERS_W-1:0] sel_rd;
	logic                 sel_wr;
	assign sel_rd = hit ? ent_readers_q[hit_idx] : '0;
	assign sel_wr = hit ? ent_writer_q[hit_idx] : 1'b0;

	// Next state and status for the request in the input register
	status_t               st;
	logic [GLOBAL_W-1:0]   n_glob_rd;
	logic [GLOBAL_W-1:0]   n_glob_wr;
	logic [BLK_WR_W-1:0]   n_blk_wr_total;
	logic [BLK_LOCK_W-1:0] n_blk_lock_total;
	logic                  n_discard;
	logic                  ent_we;
	logic                  ent_alloc;
	logic [IDX_W-1:0]      ent_idx;
	logic [READERS_W-1:0]  ent_rd;
	logic                  ent_wr;
	logic                  held;
	logic                  rel_wr;

	always_comb begin
		st               = ST_ERROR;
		n_glob_rd        = glob_rd_q;
		n_glob_wr        = glob_wr_q;
		n_blk_wr_total   = blk_wr_total_q;
		n_blk_lock_total = blk_lock_total_q;
		n_discard        = discard_q;
		ent_we           = 1'b0;
		ent_alloc        = 1'b0;
		ent_idx          = hit_idx;
		ent_rd           = sel_rd;
		ent_wr           = sel_wr;
		held             = 1'b0;
		rel_wr           = (req_type_s1 == REQ_REL_WRITE);
		unique case (req_type_s1) inside
			REQ_ACQ_READ: begin
				if (discard_q) begin
					st = ST_REFUSED;
				end else if (is_global_s1) begin
					if (glob_wr_q != '0 || blk_wr_total_q != '0) begin
						st = ST_WAIT;
					end else if (glob_rd_q == GLOBAL_MAX) begin
						st = ST_ERROR;
					end else begin
						n_glob_rd = glob_rd_q + 1'b1;
						st        = ST_GRANTED;
					end
				end else if (glob_wr_q != '0 || sel_wr) begin
					st = ST_WAIT;
				end else if (blk_lock_total_q == BLK_LOCK_MAX) begin
					st = ST_ERROR;
				end else if (!hit && !free_found) begin
					st = ST_ERROR;
				end else if (hit && sel_rd >= READERS_W'(READER_LIMIT)) begin
					st = ST_ERROR;
				end else begin
					ent_we           = 1'b1;
					ent_alloc        = !hit;
					ent_idx          = hit ? hit_idx : free_idx;
					ent_rd           = sel_rd + 1'b1;
					n_blk_lock_total = blk_lock_total_q + 1'b1;
					st               = ST_GRANTED;
				end
			end
			REQ_ACQ_WRITE: begin
				if (is_global_s1) begin
					held = glob_rd_q != '0 || glob_wr_q != '0 || blk_lock_total_q != '0;
				end else begin
					held = glob_rd_q != '0 || glob_wr_q != '0 || sel_rd != '0 || sel_wr;
				end
				if (discard_q && !even_s1) begin
					st = ST_REFUSED;
				end else if (blk_wr_total_q >= write_cap_q || held) begin
					st = ST_WAIT;
				end else if (is_global_s1) begin
					if (glob_wr_q == GLOBAL_MAX) begin
						st = ST_ERROR;
					end else begin
						n_glob_wr = glob_wr_q + 1'b1;
						st        = ST_GRANTED;
					end
				end else if (blk_wr_total_q == BLK_WR_MAX ||
						blk_lock_total_q == BLK_LOCK_MAX || !free_found) begin
					st = ST_ERROR;
				end else begin
					ent_we           = 1'b1;
					ent_alloc        = 1'b1;
					ent_idx          = free_idx;
					ent_rd           = '0;
					ent_wr           = 1'b1;
					n_blk_wr_total   = blk_wr_total_q + 1'b1;
					n_blk_lock_total = blk_lock_total_q + 1'b1;
					st               = ST_GRANTED;
				end
			end
			REQ_REL_READ, REQ_REL_WRITE: begin
				if (is_global_s1) begin
					if (rel_wr) begin
						if (glob_wr_q == '0) begin
							st = ST_ERROR;
						end else begin
							n_glob_wr = glob_wr_q - 1'b1;
							st        = ST_RELEASED;
						end
					end else if (glob_rd_q == '0) begin
						st = ST_ERROR;
					end else begin
						n_glob_rd = glob_rd_q - 1'b1;
						st        = ST_RELEASED;
					end
				end else if (!hit) begin
					st = ST_ERROR;
				end else if (rel_wr ? !sel_wr : (sel_rd == '0)) begin
					st = ST_ERROR;
				end else begin
					ent_we = 1'b1;
					if (rel_wr) begin
						ent_wr = 1'b0;
						if (blk_wr_total_q != '0) begin
							n_blk_wr_total = blk_wr_total_q - 1'b1;
						end
					end else begin
						ent_rd = sel_rd - 1'b1;
					end
					if (blk_lock_total_q != '0) begin
						n_blk_lock_total = blk_lock_total_q - 1'b1;
					end
					st = ST_RELEASED;
				end
			end
			REQ_DISCARD: begin
				n_discard = 1'b1;
				st        = ST_DISCARD;
			end
			default: begin
				st = ST_ERROR;
			end
		endcase
	end

	// Lock counts of the addressed block after this request
	logic [READERS_W-1:0] res_rd;
	logic                 res_wr;
	assign res_rd = is_global_s1 ? '0 : (ent_we ? ent_rd : sel_rd);
	assign res_wr = is_global_s1 ? 1'b0 : (ent_we ? ent_wr : sel_wr);

	// Hold control state: handshake flags, register, totals and the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			out_valid_q      <= 1'b0;
			write_cap_q      <= CAP_RESET;
			discard_q        <= 1'b0;
			glob_rd_q        <= '0;
			glob_wr_q        <= '0;
			blk_wr_total_q   <= '0;
			blk_lock_total_q <= '0;
			ent_valid_q      <= '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				ent_readers_q[i] <= '0;
				ent_writer_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				write_cap_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				discard_q        <= n_discard;
				glob_rd_q        <= n_glob_rd;
				glob_wr_q        <= n_glob_wr;
				blk_wr_total_q   <= n_blk_wr_total;
				blk_lock_total_q <= n_blk_lock_total;
				if (ent_we) begin
					ent_readers_q[ent_idx] <= ent_rd;
					ent_writer_q[ent_idx]  <= ent_wr;
					// drop the entry once it holds no lock
					ent_valid_q[ent_idx]   <= (ent_rd != '0) || ent_wr;
				end
			end
		end
	end

	// Block tags, and payload of the input and result registers
	always_ff @(posedge clk) begin
		if (advance && ent_we && ent_alloc) begin
			ent_block_q[ent_idx] <= block_s1;
		end
		if (in_xfer) begin
			req_type_s1  <= s_tuser[2:0];
			is_global_s1 <= s_tuser[3];
			even_s1      <= s_tuser[4];
			block_s1     <= s_tdata;
		end
		if (advance) begin
			status_q      <= st;
			out_readers_q <= res_rd;
			out_writer_q  <= res_wr;
		end
	end

	// Drive the result stream
	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {7'd0, out_writer_q, out_readers_q};

endmodule
